FILE: rtl/core/mji_pkg.sv
// Package for the minimum-jerk interpolator: item types and fixed-point constants.
`timescale 1ns / 1ps

package mji_pkg;

  // Fixed-point format of s, s^2, s^3, q and p
  localparam int FracBits = 24;
  localparam int OneQ     = 1 << FracBits;
  localparam int HalfQ    = 1 << (FracBits - 1);
  localparam int TenQ     = 10 * OneQ;

  // Interval count register
  localparam int IntervalsW      = 11;
  localparam int MaxIntervals    = 1024;
  localparam int NumIntervalsRst = 64;

  // Long division of step by n, a few quotient bits per stage
  localparam int DivBitsPerStage = 4;
  localparam int DivStages       = FracBits / DivBitsPerStage;

  typedef struct packed {
    logic        [5:0]            joint_index;
    logic        [IntervalsW-1:0] step_index;
    logic signed [31:0]           start_position;
    logic signed [31:0]           end_position;
  } mji_in_t;

  typedef struct packed {
    logic        [5:0]            out_joint;
    logic        [IntervalsW-1:0] out_step;
    logic signed [31:0]           position;
  } mji_out_t;

  // Side data that rides along the pipeline next to the arithmetic
  typedef struct packed {
    logic        [5:0]            joint;
    logic        [IntervalsW-1:0] step;
    logic signed [31:0]           x0;
    logic signed [32:0]           d;
  } mji_side_t;

endpackage

FILE: rtl/core/min_jerk_interpolator_core.sv
// Minimum-jerk quintic point interpolator, fully pipelined.
`timescale 1ns / 1ps

// Channel  | dir | handshake                | beat
// ---------+-----+--------------------------+------------------------------------------
// in       | in  | in_valid_i / in_ready_o  | mji_in_t: joint, step, start, end (Q16.16)
// out      | out | out_valid_o / out_ready_i| mji_out_t: joint, saturated step, position
// cfg      | in  | cfg_valid_i / cfg_ready_o| num_intervals (11 bits), always accepted
//
// One beat per cycle sustained while out_ready_i is high; thirteen register stages (stage 0,
// six long-division stages of 4 quotient bits, then s^2, s^3/q, p, d*p, rounding, final
// add). The division of step by n sets the depth.
// Reset clears every stage valid and loads num_intervals = 64.
// Each stage holds while its successor is full and stalled; bubbles close up, so
// the input keeps flowing while a result waits at the output until all thirteen
// stages are full. Nothing is dropped or repeated.
module min_jerk_interpolator_core
  import mji_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mji_in_t               in_data_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mji_out_t              out_data_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IntervalsW-1:0] cfg_data_i
);

  // Stage numbering
  localparam int StgS2  = DivStages + 1;  // s^2
  localparam int StgS3  = DivStages + 2;  // s^3 and q
  localparam int StgP   = DivStages + 3;  // blend p(s)
  localparam int StgMul = DivStages + 4;  // d * p
  localparam int StgRnd = DivStages + 5;  // rounded shift
  localparam int StgOut = DivStages + 6;  // output register
  localparam int NumStg = DivStages + 7;

  localparam logic signed [35:0] PosMax = 36'sh07FFFFFFF;
  localparam logic signed [35:0] PosMin = 36'shF80000000;

  // ---------------------------------------------------------------------------
  // Interval count: clamped to [1, MaxIntervals] as it is written, so the
  // datapath always sees the effective value.
  // ---------------------------------------------------------------------------
  logic [IntervalsW-1:0] n_q, n_d;

  always_comb begin
    if (cfg_data_i == '0) begin
      n_d = IntervalsW'(1);
    end else if (int'(cfg_data_i) > MaxIntervals) begin
      n_d = IntervalsW'(MaxIntervals);
    end else begin
      n_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= IntervalsW'(NumIntervalsRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      n_q <= n_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg-1:0] en;

  assign en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;

  for (genvar k = 0; k < NumStg - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  // Valid offered to each stage by its predecessor
  assign vld_in = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // Side data: joint, saturated step, start position and span
  mji_side_t side_q [NumStg-1];

  // ---------------------------------------------------------------------------
  // Stage 0: saturate the step, form the span, seed the division.
  // step <= n, so the integer quotient bit is set only at step == n.
  // ---------------------------------------------------------------------------
  logic [IntervalsW-1:0] rem_q [DivStages+1];
  logic [FracBits:0]     quo_q [DivStages+1];
  logic [IntervalsW-1:0] step_sat;

  assign step_sat = (in_data_i.step_index > n_q) ? n_q : in_data_i.step_index;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0].joint <= in_data_i.joint_index;
      side_q[0].step  <= step_sat;
      side_q[0].x0    <= in_data_i.start_position;
      side_q[0].d     <= $signed({in_data_i.end_position[31], in_data_i.end_position})
                       - $signed({in_data_i.start_position[31], in_data_i.start_position});
      if (step_sat == n_q) begin
        rem_q[0] <= '0;
        quo_q[0] <= (FracBits+1)'(OneQ);
      end else begin
        rem_q[0] <= step_sat;
        quo_q[0] <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..DivStages: restoring division, DivBitsPerStage fraction bits each.
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < DivStages; j++) begin : g_div
    logic [IntervalsW-1:0]      rem_d;
    logic [DivBitsPerStage-1:0] bits_d;
    logic [FracBits:0]          quo_d;

    always_comb begin : p_div
      logic [IntervalsW:0] twice;
      rem_d  = rem_q[j];
      bits_d = '0;
      for (int b = 0; b < DivBitsPerStage; b++) begin
        twice = {rem_d, 1'b0};
        if (twice >= {1'b0, n_q}) begin
          rem_d                          = IntervalsW'(twice - {1'b0, n_q});
          bits_d[DivBitsPerStage-1-b]    = 1'b1;
        end else begin
          rem_d = twice[IntervalsW-1:0];
        end
      end
      quo_d = quo_q[j];
      quo_d[FracBits-1-DivBitsPerStage*j -: DivBitsPerStage] = bits_d;
    end

    always_ff @(posedge clk_i) begin
      if (en[j+1]) begin
        rem_q[j+1] <= rem_d;
        quo_q[j+1] <= quo_d;
      end
    end
  end

  for (genvar k = 1; k < NumStg - 1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s^2 = round(s*s)
  // ---------------------------------------------------------------------------
  logic [FracBits:0]     s_q, s2_q;
  logic [2*FracBits+1:0] sq;

  assign sq = (2*FracBits+2)'(quo_q[DivStages]) * (2*FracBits+2)'(quo_q[DivStages]);

  always_ff @(posedge clk_i) begin
    if (en[StgS2]) begin
      s_q  <= quo_q[DivStages];
      s2_q <= (FracBits+1)'((sq + (2*FracBits+2)'(HalfQ)) >> FracBits);
    end
  end

  // ---------------------------------------------------------------------------
  // s^3 = round(s^2*s); q = 10 - 15s + 6s^2, floored at zero
  // ---------------------------------------------------------------------------
  logic [FracBits:0]     s3_q;
  logic [28:0]           q_q;
  logic [2*FracBits+1:0] cube;
  logic [29:0]           q_pos, s15;

  assign cube  = (2*FracBits+2)'(s2_q) * (2*FracBits+2)'(s_q);
  assign q_pos = 30'(TenQ) + 30'(s2_q) * 30'd6;
  assign s15   = 30'(s_q) * 30'd15;

  always_ff @(posedge clk_i) begin
    if (en[StgS3]) begin
      s3_q <= (FracBits+1)'((cube + (2*FracBits+2)'(HalfQ)) >> FracBits);
      q_q  <= (q_pos > s15) ? 29'(q_pos - s15) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // p = round(s^3 * q), capped at one
  // ---------------------------------------------------------------------------
  logic [FracBits:0] p_q;
  logic [53:0]       pq;
  logic [29:0]       p_wide;

  assign pq     = 54'(s3_q) * 54'(q_q);
  assign p_wide = 30'((pq + 54'(HalfQ)) >> FracBits);

  always_ff @(posedge clk_i) begin
    if (en[StgP]) begin
      p_q <= (p_wide > 30'(OneQ)) ? (FracBits+1)'(OneQ) : (FracBits+1)'(p_wide);
    end
  end

  // ---------------------------------------------------------------------------
  // d * p
  // ---------------------------------------------------------------------------
  logic signed [58:0] dp_q;

  always_ff @(posedge clk_i) begin
    if (en[StgMul]) begin
      dp_q <= 59'(side_q[StgMul-1].d) * 59'($signed({1'b0, p_q}));
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by 2^24, half away from zero: bias by half, less one when negative
  // ---------------------------------------------------------------------------
  logic signed [34:0] quot_q;
  logic signed [58:0] biased;

  assign biased = dp_q + (dp_q[58] ? 59'(HalfQ - 1) : 59'(HalfQ));

  always_ff @(posedge clk_i) begin
    if (en[StgRnd]) begin
      quot_q <= 35'(biased >>> FracBits);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: start + offset, saturated to 32 bits
  // ---------------------------------------------------------------------------
  mji_out_t           out_q;
  logic signed [35:0] pos_sum;

  assign pos_sum = 36'(side_q[StgOut-1].x0) + 36'(quot_q);

  always_ff @(posedge clk_i) begin
    if (en[StgOut]) begin
      out_q.out_joint <= side_q[StgOut-1].joint;
      out_q.out_step  <= side_q[StgOut-1].step;
      if (pos_sum > PosMax) begin
        out_q.position <= 32'sh7FFFFFFF;
      end else if (pos_sum < PosMin) begin
        out_q.position <= 32'sh80000000;
      end else begin
        out_q.position <= 32'(pos_sum);
      end
    end
  end

  assign out_data_o = out_q;

endmodule
